// ===== rtl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

   // result kinds
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERR   = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
   localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN    = 3'd4;
   localparam logic [2:0] ERR_UNTERM     = 3'd5;

   // closing element of a queued burst
   localparam logic [1:0] TAIL_NONE  = 2'd0;
   localparam logic [1:0] TAIL_CLOSE = 2'd1;
   localparam logic [1:0] TAIL_ERR   = 2'd2;

   // most text bytes one input byte can cause
   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   // burst queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // one queued burst: text bytes, then an optional close or error
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          nbytes;
      logic [1:0]                tail;
      logic [2:0]                err;
   } ent_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      ent_type ent;
   } head_type;

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
`default_nettype none
// channel  valid      ready      payload
// req      req_valid  req_ready  req_in_byte, req_start_req, req_input_end
// rsp      rsp_valid  rsp_ready  rsp_out_byte, rsp_kind, rsp_err_code, rsp_last
//
// one input byte is taken every cycle while the four-entry burst queue has room
// each byte is classified in the cycle it is taken and queues one burst of 0 to 6 results
// the back end hands out one result per cycle while rsp_ready is high
// reset is synchronous and returns the decoder to idle with an empty queue
// a stalled rsp side fills the queue, then req_ready drops until a burst drains
module json_string_unescape_utf8 import jsu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_start_req,
   input  wire logic       req_input_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_err_code,
   output logic            rsp_last
);

   logic     full;
   logic     accept;
   logic     push;
   ent_type  push_ent;
   logic     pop;
   head_type head;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   // decoder
   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .start_req (req_start_req),
      .input_end (req_input_end),
      .push      (push),
      .push_ent  (push_ent)
   );

   // burst queue
   jsu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   // result sequencer
   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_err_code (rsp_err_code),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

// ===== rtl/jsu_front.sv =====
`default_nettype none
module jsu_front import jsu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       start_req,
   input  wire logic       input_end,
   output logic            push,
   output ent_type         push_ent
);

   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_BODY = 4'd1;
   localparam logic [3:0] PH_ESC  = 4'd2;
   localparam logic [3:0] PH_HEX  = 4'd3;
   localparam logic [3:0] PH_DONE = 4'd4;
   localparam logic [3:0] PH_ERR  = 4'd8;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      n;
   } enc_type;

   // utf-8 encoding of a code point
   function automatic enc_type utf8_enc(input logic [20:0] cp);
      enc_type e;
      e = '0;
      if (cp < 21'h80) begin
         e.n = 3'd1;
         e.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         e.n = 3'd2;
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         e.n = 3'd3;
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         e.n = 3'd4;
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

   logic [3:0]  phase_ff, phase_in;
   logic [11:0] hex_accum_ff, hex_accum_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [9:0]  held_high_ff, held_high_in;
   logic        holding_high_ff, holding_high_in;

   logic        use_flush;
   enc_type     flush_enc;
   enc_type     main_enc;
   logic [1:0]  tail;
   logic [2:0]  err;

   logic        hex_ok;
   logic [3:0]  hex_d;
   logic [15:0] cp16;
   logic [20:0] pair_cp;
   logic        short_ok;
   logic [7:0]  short_ch;

   // hex digit value
   always_comb begin
      hex_ok = 1'b1;
      hex_d  = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_d = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         hex_d = in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // short escapes
   always_comb begin
      short_ok = 1'b1;
      short_ch = 8'h00;
      unique case (in_byte)
         8'h22:   short_ch = 8'h22;
         8'h5C:   short_ch = 8'h5C;
         8'h2F:   short_ch = 8'h2F;
         8'h62:   short_ch = 8'h08;
         8'h66:   short_ch = 8'h0C;
         8'h6E:   short_ch = 8'h0A;
         8'h72:   short_ch = 8'h0D;
         8'h74:   short_ch = 8'h09;
         default: short_ok = 1'b0;
      endcase
   end

   assign cp16      = {hex_accum_ff, hex_d};
   assign pair_cp   = 21'h10000 + {1'b0, held_high_ff, cp16[9:0]};
   assign flush_enc = utf8_enc({5'd0, 6'b110110, held_high_ff});

   // classify the accepted byte and plan its burst
   always_comb begin
      phase_in        = phase_ff;
      hex_accum_in    = hex_accum_ff;
      digit_count_in  = digit_count_ff;
      held_high_in    = held_high_ff;
      holding_high_in = holding_high_ff;
      push            = 1'b0;
      use_flush       = 1'b0;
      main_enc        = '0;
      tail            = TAIL_NONE;
      err             = ERR_NONE;
      if (accept) begin
         if (start_req) begin
            hex_accum_in    = '0;
            digit_count_in  = '0;
            held_high_in    = '0;
            holding_high_in = 1'b0;
            if (input_end || in_byte != CH_QUOTE) begin
               err = ERR_NO_QUOTE;
            end else begin
               phase_in = PH_BODY;
            end
         end else if (phase_ff[3]) begin
            err = phase_ff[2:0];
         end else begin
            unique case (phase_ff)
               PH_BODY: begin
                  if (input_end) begin
                     err = ERR_UNTERM;
                  end else if (in_byte == CH_BSL) begin
                     phase_in = PH_ESC;
                  end else begin
                     use_flush       = holding_high_ff;
                     holding_high_in = 1'b0;
                     held_high_in    = '0;
                     push            = 1'b1;
                     if (in_byte == CH_QUOTE) begin
                        phase_in = PH_DONE;
                        tail     = TAIL_CLOSE;
                     end else begin
                        main_enc.n        = 3'd1;
                        main_enc.bytes[0] = in_byte;
                     end
                  end
               end
               PH_ESC: begin
                  if (input_end) begin
                     err = ERR_INCOMPLETE;
                  end else if (in_byte == CH_U) begin
                     phase_in       = PH_HEX;
                     hex_accum_in   = '0;
                     digit_count_in = '0;
                  end else if (!short_ok) begin
                     err = ERR_UNKNOWN;
                  end else begin
                     use_flush         = holding_high_ff;
                     holding_high_in   = 1'b0;
                     held_high_in      = '0;
                     push              = 1'b1;
                     main_enc.n        = 3'd1;
                     main_enc.bytes[0] = short_ch;
                     phase_in          = PH_BODY;
                  end
               end
               PH_HEX: begin
                  if (input_end) begin
                     err = ERR_INCOMPLETE;
                  end else if (!hex_ok) begin
                     err = ERR_BAD_HEX;
                  end else if (digit_count_ff != 2'd3) begin
                     hex_accum_in   = cp16[11:0];
                     digit_count_in = digit_count_ff + 2'd1;
                  end else begin
                     hex_accum_in   = '0;
                     digit_count_in = '0;
                     phase_in       = PH_BODY;
                     if (holding_high_ff && cp16 >= 16'hDC00 && cp16 <= 16'hDFFF) begin
                        main_enc        = utf8_enc(pair_cp);
                        holding_high_in = 1'b0;
                        held_high_in    = '0;
                        push            = 1'b1;
                     end else begin
                        use_flush = holding_high_ff;
                        if (cp16 >= 16'hD800 && cp16 <= 16'hDBFF) begin
                           held_high_in    = cp16[9:0];
                           holding_high_in = 1'b1;
                           push            = holding_high_ff;
                        end else begin
                           holding_high_in = 1'b0;
                           held_high_in    = '0;
                           main_enc        = utf8_enc({5'd0, cp16});
                           push            = 1'b1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         // an error drops everything else from this byte
         if (err != ERR_NONE) begin
            phase_in        = PH_ERR | {1'b0, err};
            holding_high_in = 1'b0;
            held_high_in    = '0;
            push            = 1'b1;
            use_flush       = 1'b0;
            main_enc        = '0;
            tail            = TAIL_ERR;
         end
      end
   end

   // pack flushed surrogate and main bytes into one burst
   always_comb begin
      push_ent.tail = tail;
      push_ent.err  = err;
      if (use_flush) begin
         push_ent.nbytes   = CNT_W'(main_enc.n) + CNT_W'(3);
         push_ent.bytes[0] = flush_enc.bytes[0];
         push_ent.bytes[1] = flush_enc.bytes[1];
         push_ent.bytes[2] = flush_enc.bytes[2];
         push_ent.bytes[3] = main_enc.bytes[0];
         push_ent.bytes[4] = main_enc.bytes[1];
         push_ent.bytes[5] = main_enc.bytes[2];
      end else begin
         push_ent.nbytes   = CNT_W'(main_enc.n);
         push_ent.bytes[0] = main_enc.bytes[0];
         push_ent.bytes[1] = main_enc.bytes[1];
         push_ent.bytes[2] = main_enc.bytes[2];
         push_ent.bytes[3] = main_enc.bytes[3];
         push_ent.bytes[4] = 8'h00;
         push_ent.bytes[5] = 8'h00;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         hex_accum_ff    <= '0;
         digit_count_ff  <= '0;
         held_high_ff    <= '0;
         holding_high_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         hex_accum_ff    <= hex_accum_in;
         digit_count_ff  <= digit_count_in;
         held_high_ff    <= held_high_in;
         holding_high_ff <= holding_high_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/jsu_fifo.sv =====
`default_nettype none
module jsu_fifo import jsu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  ent_type      push_ent,
   input  wire logic    pop,
   output logic         full,
   output head_type     head
);

   ent_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.ent   = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // burst storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
`default_nettype none
module jsu_back import jsu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  head_type        head,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_err_code,
   output logic            rsp_last
);

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] total;
   logic             is_text;
   logic             xfer;

   assign total     = head.ent.nbytes + CNT_W'(head.ent.tail != TAIL_NONE);
   assign is_text   = (idx_ff < head.ent.nbytes);
   assign rsp_valid = head.valid;
   assign rsp_last  = (idx_ff == total - 1'b1);
   assign xfer      = rsp_valid && rsp_ready;
   assign pop       = xfer && rsp_last;

   // select the current element of the head burst
   always_comb begin
      rsp_out_byte = 8'h00;
      rsp_kind     = KIND_TEXT;
      rsp_err_code = ERR_NONE;
      if (is_text) begin
         rsp_out_byte = head.ent.bytes[idx_ff];
      end else if (head.ent.tail == TAIL_CLOSE) begin
         rsp_kind = KIND_CLOSE;
      end else begin
         rsp_kind     = KIND_ERR;
         rsp_err_code = head.ent.err;
      end
   end

   // step through the burst on each transfer
   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = rsp_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_json_string_unescape_utf8.sv =====
`default_nettype none
module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   // characters with a role in the token syntax
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   // letters of the short escapes
   localparam logic [63:0] ESC_SET = "\"\\/bfnrt";

   localparam int unsigned RANDOM_ITEMS = 470;
   localparam int unsigned PAUSE_EVERY  = 150;
   localparam int unsigned DRAIN_LIMIT  = 20000;

   // decoder phases of the predictor
   typedef enum logic [2:0] {
      ST_IDLE, ST_BODY, ST_ESCAPE, ST_HEX, ST_CLOSED, ST_FAILED
   } dec_phase_type;

   // one result transfer
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [2:0] err;
      logic       last;
   } utf8_rsp_type;

   // one directed row: check set means the result is typed in here,
   // quiet set means no result at all
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       fin;
      logic       check;
      logic       quiet;
      logic [7:0] x_data;
      logic [1:0] x_kind;
      logic [2:0] x_err;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_start_req;
   logic       req_input_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_err_code;
   logic       rsp_last;

   json_string_unescape_utf8 dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_start_req(req_start_req),
      .req_input_end(req_input_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_err_code (rsp_err_code),
      .rsp_last     (rsp_last)
   );

   // predictor state
   dec_phase_type dec_phase   = ST_IDLE;
   logic [2:0]    sticky_code = ERR_NONE;
   logic [15:0]   hex_acc     = '0;
   logic [1:0]    hex_cnt     = '0;
   logic [9:0]    held_hi     = '0;
   logic          hi_pending  = 1'b0;

   utf8_rsp_type  step_out[$];
   utf8_rsp_type  utf8_expected[$];
   stim_row_type  dir_tab[$];
   int unsigned   items_sent = 0;
   int unsigned   mismatches = 0;
   logic          send_calm  = 1'b0;
   logic          recv_calm  = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // hex digit value, -1 when not a digit
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   // short escape letter to {known, character}
   function automatic logic [8:0] escape_char(input logic [7:0] c);
      case (c)
         8'h22:   return {1'b1, 8'h22};
         8'h5C:   return {1'b1, 8'h5C};
         8'h2F:   return {1'b1, 8'h2F};
         8'h62:   return {1'b1, 8'h08};
         8'h66:   return {1'b1, 8'h0C};
         8'h6E:   return {1'b1, 8'h0A};
         8'h72:   return {1'b1, 8'h0D};
         8'h74:   return {1'b1, 8'h09};
         default: return 9'h000;
      endcase
   endfunction

   function automatic void put_text(input logic [7:0] d);
      step_out.insert(step_out.size(), utf8_rsp_type'{d, KIND_TEXT, ERR_NONE, 1'b0});
   endfunction

   // utf-8 encoding of one code point
   function automatic void put_cp(input logic [20:0] cp);
      if (cp < 21'h80) begin
         put_text(cp[7:0]);
      end else if (cp < 21'h800) begin
         put_text({3'b110, cp[10:6]});
         put_text({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         put_text({4'b1110, cp[15:12]});
         put_text({2'b10, cp[11:6]});
         put_text({2'b10, cp[5:0]});
      end else begin
         put_text({5'b11110, cp[20:18]});
         put_text({2'b10, cp[17:12]});
         put_text({2'b10, cp[11:6]});
         put_text({2'b10, cp[5:0]});
      end
   endfunction

   // a pending high surrogate goes out on its own
   function automatic void flush_high();
      if (hi_pending) begin
         put_cp({5'b0, 6'b110110, held_hi});
         hi_pending = 1'b0;
         held_hi    = '0;
      end
   endfunction

   // an error replaces everything this byte would have produced
   function automatic void fail_with(input logic [2:0] code);
      dec_phase   = ST_FAILED;
      sticky_code = code;
      hi_pending  = 1'b0;
      held_hi     = '0;
      step_out.delete();
      step_out.insert(0, utf8_rsp_type'{8'h00, KIND_ERR, code, 1'b0});
   endfunction

   // predicted results of one accepted input byte, left in step_out
   function automatic void decode_byte(input logic [7:0] b, input logic s, input logic e);
      int         d;
      logic [8:0] esc;
      logic [15:0] cp;
      step_out.delete();
      if (s) begin
         dec_phase   = ST_IDLE;
         sticky_code = ERR_NONE;
         hex_acc     = '0;
         hex_cnt     = '0;
         held_hi     = '0;
         hi_pending  = 1'b0;
         if (e || b != CH_QUOTE) fail_with(ERR_NO_QUOTE);
         else dec_phase = ST_BODY;
      end else begin
         case (dec_phase)
            ST_FAILED: begin
               step_out.insert(step_out.size(),
                               utf8_rsp_type'{8'h00, KIND_ERR, sticky_code, 1'b0});
            end
            ST_BODY: begin
               if (e) begin
                  fail_with(ERR_UNTERM);
               end else begin
                  if (b != CH_BSLASH) flush_high();
                  if (b == CH_QUOTE) begin
                     dec_phase = ST_CLOSED;
                     step_out.insert(step_out.size(),
                                     utf8_rsp_type'{8'h00, KIND_CLOSE, ERR_NONE, 1'b0});
                  end else if (b == CH_BSLASH) begin
                     dec_phase = ST_ESCAPE;
                  end else begin
                     put_text(b);
                  end
               end
            end
            ST_ESCAPE: begin
               esc = escape_char(b);
               if (e) begin
                  fail_with(ERR_INCOMPLETE);
               end else if (b == CH_U) begin
                  dec_phase = ST_HEX;
                  hex_acc   = '0;
                  hex_cnt   = '0;
               end else if (!esc[8]) begin
                  fail_with(ERR_UNKNOWN);
               end else begin
                  flush_high();
                  put_text(esc[7:0]);
                  dec_phase = ST_BODY;
               end
            end
            ST_HEX: begin
               d = hex_digit(b);
               if (e) begin
                  fail_with(ERR_INCOMPLETE);
               end else if (d < 0) begin
                  fail_with(ERR_BAD_HEX);
               end else begin
                  hex_acc = {hex_acc[11:0], d[3:0]};
                  if (hex_cnt != 2'd3) begin
                     hex_cnt = hex_cnt + 2'd1;
                  end else begin
                     cp        = hex_acc;
                     hex_acc   = '0;
                     hex_cnt   = '0;
                     dec_phase = ST_BODY;
                     // low surrogate right after a high one joins it
                     if (hi_pending && cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                        put_cp(21'h10000 + {held_hi, cp[9:0]});
                        hi_pending = 1'b0;
                        held_hi    = '0;
                     end else begin
                        flush_high();
                        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                           held_hi    = cp[9:0];
                           hi_pending = 1'b1;
                        end else begin
                           put_cp({5'b0, cp});
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // idle length, mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // hex digit character in random case
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // code point drawn from the encoding ranges and their edges
   function automatic logic [15:0] pick_cp();
      case ($urandom_range(0, 6))
         0: return 16'($urandom_range(16'h0000, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hD7FF));
         3: return 16'($urandom_range(16'hE000, 16'hFFFF));
         4: return 16'($urandom_range(16'hD800, 16'hDBFF));
         5: return 16'($urandom_range(16'hDC00, 16'hDFFF));
         default: begin
            case ($urandom_range(0, 9))
               0:       return 16'h0000;
               1:       return 16'h007F;
               2:       return 16'h0080;
               3:       return 16'h07FF;
               4:       return 16'h0800;
               5:       return 16'hFFFF;
               6:       return 16'hD800;
               7:       return 16'hDBFF;
               8:       return 16'hDC00;
               default: return 16'hDFFF;
            endcase
         end
      endcase
   endfunction

   // one request transfer; entered and left at a falling edge
   task automatic push_req(input logic [7:0] b, input logic s, input logic e,
                           input logic use_model);
      int unsigned gap;
      gap = send_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_start_req <= s;
      req_input_end <= e;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_byte(b, s, e);
      if (use_model)
         foreach (step_out[k]) utf8_expected.insert(utf8_expected.size(), step_out[k]);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic feed(input logic [7:0] b);
      push_req(b, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic send_u(input logic [15:0] v);
      feed(CH_BSLASH);
      feed(CH_U);
      for (int i = 3; i >= 0; i--) feed(hex_char(v[4*i +: 4]));
   endtask

   // sender holds off until every predicted result has come
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(negedge clock); while (utf8_expected.size() != 0);
   endtask

   // a few items after a closed or failed token
   task automatic trail_items(input logic allow_end);
      repeat ($urandom_range(0, 2))
         push_req(8'($urandom_range(0, 255)), 1'b0,
                  allow_end & 1'($urandom_range(0, 1)), 1'b1);
   endtask

   // one random string token, mostly well formed
   task automatic gen_token();
      int unsigned n_el;
      int unsigned r;
      logic [7:0]  b;
      logic        e;
      // broken opening
      if ($urandom_range(0, 99) < 8) begin
         b = 8'($urandom_range(0, 255));
         e = 1'($urandom_range(0, 1));
         if (b == CH_QUOTE && !e) b = 8'h27;
         push_req(b, 1'b1, e, 1'b1);
         trail_items(1'b1);
         return;
      end
      push_req(CH_QUOTE, 1'b1, 1'b0, 1'b1);
      n_el = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
      repeat (n_el) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
            feed(b);
         end else if (r < 55) begin
            feed(CH_BSLASH);
            feed(ESC_SET[8*$urandom_range(0, 7) +: 8]);
         end else if (r < 75) begin
            send_u(pick_cp());
         end else if (r < 90) begin
            send_u(16'hD800 + 16'($urandom_range(0, 10'h3FF)));
            send_u(16'hDC00 + 16'($urandom_range(0, 10'h3FF)));
         end else begin
            // broken escape ends the token
            feed(CH_BSLASH);
            case ($urandom_range(0, 3))
               0: begin
                  do b = 8'($urandom_range(0, 255));
                  while (escape_char(b) != 9'h000 || b == CH_U);
                  feed(b);
               end
               1: begin
                  feed(CH_U);
                  repeat ($urandom_range(0, 3)) feed(hex_char(4'($urandom_range(0, 15))));
                  do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
                  feed(b);
               end
               2: begin
                  push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
               end
               default: begin
                  feed(CH_U);
                  repeat ($urandom_range(0, 3)) feed(hex_char(4'($urandom_range(0, 15))));
                  push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
               end
            endcase
            trail_items(1'b1);
            return;
         end
      end
      // closing quote, end of input, or a restart with no close
      r = $urandom_range(0, 9);
      if (r < 8) begin
         feed(CH_QUOTE);
         if ($urandom_range(0, 3) == 0) trail_items(1'b1);
      end else if (r == 8) begin
         push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
      end
   endtask

   // stimulus
   initial begin
      int unsigned target;
      int unsigned next_pause;
      int unsigned waited;
      dir_tab = '{
         '{"a",       1'b0, 1'b0, 1'b1, 1'b1, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"x",       1'b1, 1'b0, 1'b1, 1'b0, 8'h00, KIND_ERR,   ERR_NO_QUOTE},
         '{"q",       1'b0, 1'b0, 1'b1, 1'b0, 8'h00, KIND_ERR,   ERR_NO_QUOTE},
         '{CH_QUOTE,  1'b1, 1'b1, 1'b1, 1'b0, 8'h00, KIND_ERR,   ERR_NO_QUOTE},
         '{CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b1, 8'h00, KIND_TEXT,  ERR_NONE},
         '{8'h00,     1'b0, 1'b0, 1'b1, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{8'hFF,     1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, KIND_TEXT,  ERR_NONE},
         '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"D",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"8",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"3",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"d",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"D",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"E",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"0",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"0",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{CH_QUOTE,  1'b0, 1'b0, 1'b1, 1'b0, 8'h00, KIND_CLOSE, ERR_NONE},
         '{"z",       1'b0, 1'b0, 1'b1, 1'b1, 8'h00, KIND_TEXT,  ERR_NONE},
         '{CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b1, 8'h00, KIND_TEXT,  ERR_NONE},
         '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, KIND_TEXT,  ERR_NONE},
         '{"q",       1'b0, 1'b0, 1'b1, 1'b0, 8'h00, KIND_ERR,   ERR_UNKNOWN}
      };
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = 8'h00;
      req_start_req = 1'b0;
      req_input_end = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].check && !dir_tab[i].quiet)
            utf8_expected.insert(utf8_expected.size(),
                                 utf8_rsp_type'{dir_tab[i].x_data, dir_tab[i].x_kind,
                                                dir_tab[i].x_err, 1'b1});
         push_req(dir_tab[i].data, dir_tab[i].start, dir_tab[i].fin, !dir_tab[i].check);
      end
      drain_pause();

      // random tokens with some noise
      target     = items_sent + RANDOM_ITEMS;
      next_pause = items_sent + PAUSE_EVERY;
      while (items_sent < target) begin
         if ($urandom_range(0, 15) == 0) send_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 6)
            push_req(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 7) == 0, 1'b1);
         else
            gen_token();
         if (items_sent >= next_pause) begin
            drain_pause();
            next_pause = items_sent + PAUSE_EVERY;
         end
      end
      req_valid <= 1'b0;

      // let every predicted result arrive, then watch for strays
      waited = 0;
      while (utf8_expected.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (32) @(negedge clock);
      if (utf8_expected.size() != 0) begin
         $error("%0d expected results never arrived", utf8_expected.size());
         mismatches++;
      end
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // result side: sample at the rising edge, check and move ready at the falling edge
   initial begin
      utf8_rsp_type got;
      utf8_rsp_type want;
      logic         hit;
      logic         bad;
      int unsigned  stall;
      rsp_ready = 1'b0;
      stall     = 0;
      forever begin
         @(posedge clock);
         hit = !reset && (rsp_valid === 1'b1) && rsp_ready;
         got = '{rsp_out_byte, rsp_kind, rsp_err_code, rsp_last};
         @(negedge clock);
         if (hit) begin
            if (utf8_expected.size() == 0) begin
               $error("result transfer with nothing expected: out_byte %02h kind %0d err_code %0d",
                      got.data, got.kind, got.err);
               mismatches++;
            end else begin
               want = utf8_expected.pop_front();
               bad  = 1'b0;
               if (got.data !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, got.data);
                  bad = 1'b1;
               end
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  bad = 1'b1;
               end
               if (got.err !== want.err) begin
                  $error("err_code: expected %0d, got %0d", want.err, got.err);
                  bad = 1'b1;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  bad = 1'b1;
               end
               if (bad) mismatches++;
            end
         end
         // random back pressure, with stretches of none
         if ($urandom_range(0, 299) == 0) recv_calm = ($urandom_range(0, 3) == 0);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            stall = recv_calm ? 0 : pick_gap();
            rsp_ready <= (stall == 0);
            if (stall != 0) stall--;
         end
      end
   end

endmodule
`default_nettype wire
